/* src/jet_pkg.sv */
`default_nettype none

package jet_pkg;

    // Field and register widths
    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 13;
    localparam int FRAC_W   = 31;
    localparam int QUO_W    = 32;
    localparam int CNT_W    = 11;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Fraction divider: quotient bits retired per pipeline stage
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;

    // Register map, word index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_C_REAL       = 3'd0,
        REG_C_IMAG       = 3'd1,
        REG_CENTER_REAL  = 3'd2,
        REG_CENTER_IMAG  = 3'd3,
        REG_INVERSE_ZOOM = 3'd4,
        REG_IMAGE_WIDTH  = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6,
        REG_THRESHOLD    = 3'd7
    } reg_idx_t;

    // Reset values
    localparam logic [30:0]       RST_INVERSE_ZOOM = 31'h1000_0000;
    localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 13'd800;
    localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 13'd600;
    localparam logic [30:0]       RST_THRESHOLD    = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
        logic signed [31:0] center_real;
        logic signed [31:0] center_imag;
        logic [30:0]        inverse_zoom;
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [30:0]        escape_threshold;
    } cfg_t;

    // Point in the complex plane, Q4.28
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } z_t;

    // Partial state of the restoring divider
    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } div_t;

    // Clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sh00_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < -40'sh00_8000_0000) begin
            r = -32'sh8000_0000;
        end
        else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Retire DIV_BITS quotient bits, dividend bits MSB first
    function automatic div_t div_step(div_t d, logic [DIV_BITS-1:0] bits,
                                      logic [SIZE_W-1:0] n);
        div_t          r;
        logic [SIZE_W:0] t;
        r = d;
        for (int b = DIV_BITS - 1; b >= 0; b--) begin
            t = {r.rem, bits[b]};
            if (t >= {1'b0, n}) begin
                t     = t - {1'b0, n};
                r.quo = {r.quo[QUO_W-2:0], 1'b1};
            end
            else begin
                r.quo = {r.quo[QUO_W-2:0], 1'b0};
            end
            r.rem = t[SIZE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/jet_cfg.sv */
`default_nettype none

module jet_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jet_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [jet_pkg::DATA_W-1:0]  pwdata,
    output logic      [jet_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output jet_pkg::cfg_t                    cfg
);

    jet_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.c_real           <= '0;
            cfg_reg.c_imag           <= '0;
            cfg_reg.center_real      <= '0;
            cfg_reg.center_imag      <= '0;
            cfg_reg.inverse_zoom     <= jet_pkg::RST_INVERSE_ZOOM;
            cfg_reg.image_width      <= jet_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height     <= jet_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.escape_threshold <= jet_pkg::RST_THRESHOLD;
        end
        else if (wr_en) begin
            case (paddr[4:2])
                jet_pkg::REG_C_REAL:       cfg_reg.c_real       <= pwdata;
                jet_pkg::REG_C_IMAG:       cfg_reg.c_imag       <= pwdata;
                jet_pkg::REG_CENTER_REAL:  cfg_reg.center_real  <= pwdata;
                jet_pkg::REG_CENTER_IMAG:  cfg_reg.center_imag  <= pwdata;
                jet_pkg::REG_INVERSE_ZOOM: cfg_reg.inverse_zoom <= pwdata[30:0];
                jet_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.image_width  <= pwdata[jet_pkg::SIZE_W-1:0];
                jet_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= pwdata[jet_pkg::SIZE_W-1:0];
                jet_pkg::REG_THRESHOLD:    cfg_reg.escape_threshold <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[4:2])
            jet_pkg::REG_C_REAL:       prdata = cfg_reg.c_real;
            jet_pkg::REG_C_IMAG:       prdata = cfg_reg.c_imag;
            jet_pkg::REG_CENTER_REAL:  prdata = cfg_reg.center_real;
            jet_pkg::REG_CENTER_IMAG:  prdata = cfg_reg.center_imag;
            jet_pkg::REG_INVERSE_ZOOM: prdata = {1'b0, cfg_reg.inverse_zoom};
            jet_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            jet_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            jet_pkg::REG_THRESHOLD:    prdata = {1'b0, cfg_reg.escape_threshold};
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/jet_map.sv */
`default_nettype none

// Pixel index to start point: pipelined fraction divider, then zoom and offset.
module jet_map (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire jet_pkg::cfg_t                cfg,
    input  wire logic                         in_valid,
    input  wire logic [jet_pkg::COORD_W-1:0]  in_col,
    input  wire logic [jet_pkg::COORD_W-1:0]  in_row,
    output logic                              out_valid,
    output jet_pkg::z_t                       out_z
);

    localparam int NS = jet_pkg::DIV_STAGES;
    localparam logic signed [31:0] Q28_HALF = 32'sh0800_0000;
    localparam logic [jet_pkg::FRAC_W-1:0] FRAC_MAX = 31'h7FFF_FFFF;

    // lane 0 = real (column), lane 1 = imaginary (row)
    logic [jet_pkg::COORD_W-1:0] idx      [2];
    logic [jet_pkg::SIZE_W-1:0]  size     [2];
    logic [jet_pkg::SIZE_W-1:0]  divisor  [2];
    logic                        sat_in   [2];
    logic signed [31:0]          centre   [2];
    logic [jet_pkg::FRAC_W-1:0]  frac     [2];
    logic signed [31:0]          offs     [2];
    logic signed [63:0]          prod     [2];
    logic signed [39:0]          pos      [2];

    logic [NS:0]                 vd_reg;
    logic                        vm_reg;
    logic                        va_reg;
    jet_pkg::div_t               div_reg  [NS+1][2];
    logic                        sat_reg  [NS+1][2];
    logic [jet_pkg::DIV_BITS-1:0] nib_reg [2];
    logic signed [63:0]          prod_reg [2];
    logic signed [31:0]          pos_reg  [2];

    assign idx[0]    = in_col;
    assign idx[1]    = in_row;
    assign size[0]   = cfg.image_width;
    assign size[1]   = cfg.image_height;
    assign centre[0] = cfg.center_real;
    assign centre[1] = cfg.center_imag;

    // Per-lane combinational terms
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            divisor[l] = (size[l] == '0) ? jet_pkg::SIZE_W'(1) : size[l];
            // quotient reaches 2^31 exactly when idx >= 8 * divisor
            sat_in[l]  = {4'b0, idx[l]} >= {divisor[l], 3'b000};
            frac[l]    = sat_reg[NS][l] ? FRAC_MAX
                                        : div_reg[NS][l].quo[jet_pkg::FRAC_W-1:0];
            offs[l]    = $signed({1'b0, frac[l]}) - Q28_HALF;
            prod[l]    = offs[l] * $signed({1'b0, cfg.inverse_zoom});
            pos[l]     = 40'($signed(prod_reg[l][63:28])) + 40'(centre[l]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vd_reg <= '0;
            vm_reg <= 1'b0;
            va_reg <= 1'b0;
        end
        else if (advance) begin
            vd_reg <= {vd_reg[NS-1:0], in_valid};
            vm_reg <= vd_reg[NS];
            va_reg <= vm_reg;
        end
    end

    // Datapath
    always_ff @(posedge clk) begin
        if (advance) begin
            for (int l = 0; l < 2; l++) begin
                // entry: first remainder is idx*2^28 >> 32, zero when saturated
                div_reg[0][l].rem <= sat_in[l] ? '0
                                               : jet_pkg::SIZE_W'(idx[l][11:4]);
                div_reg[0][l].quo <= '0;
                sat_reg[0][l]     <= sat_in[l];
                nib_reg[l]        <= idx[l][3:0];
                // divider stages, only the first sees nonzero dividend bits
                for (int s = 1; s <= NS; s++) begin
                    div_reg[s][l] <= jet_pkg::div_step(div_reg[s-1][l],
                                         (s == 1) ? nib_reg[l] : '0, divisor[l]);
                    sat_reg[s][l] <= sat_reg[s-1][l];
                end
                prod_reg[l] <= prod[l];
                pos_reg[l]  <= jet_pkg::sat32(pos[l]);
            end
        end
    end

    assign out_valid = va_reg;
    assign out_z.re  = pos_reg[0];
    assign out_z.im  = pos_reg[1];

endmodule

`default_nettype wire

/* src/jet_iter.sv */
`default_nettype none

// One orbit step: square stage, then combine stage with the escape test
// of the point that entered (that point is the result of step STEP; step 0 skips the test).
module jet_iter #(
    parameter int STEP = 0,
    parameter int CW   = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire jet_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    input  wire jet_pkg::z_t   in_z,
    input  wire logic [CW-1:0] in_count,
    output logic               out_valid,
    output jet_pkg::z_t        out_z,
    output logic [CW-1:0]      out_count
);

    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [39:0] re_sum;
    logic signed [39:0] im_sum;
    logic [35:0]        mag;
    logic               esc;

    logic               vm_reg;
    logic               vc_reg;
    logic [62:0]        rr_reg;
    logic [62:0]        ii_reg;
    logic signed [63:0] ri_reg;
    logic [CW-1:0]      km_reg;
    jet_pkg::z_t        z_reg;
    logic [CW-1:0]      kc_reg;

    // Products
    always_comb begin
        p_rr = $signed(in_z.re) * $signed(in_z.re);
        p_ii = $signed(in_z.im) * $signed(in_z.im);
        p_ri = $signed(in_z.re) * $signed(in_z.im);
    end

    // Next point and escape test
    always_comb begin
        re_sum = $signed({5'b0, rr_reg[62:28]}) - $signed({5'b0, ii_reg[62:28]})
               + 40'($signed(cfg.c_real));
        im_sum = 40'($signed(ri_reg[63:27])) + 40'($signed(cfg.c_imag));
        mag    = {1'b0, rr_reg[62:28]} + {1'b0, ii_reg[62:28]};
        esc    = (STEP != 0) && (km_reg == '0) && (mag > 36'(cfg.escape_threshold));
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vm_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (advance) begin
            vm_reg <= in_valid;
            vc_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            rr_reg   <= p_rr[62:0];
            ii_reg   <= p_ii[62:0];
            ri_reg   <= p_ri;
            km_reg   <= in_count;
            z_reg.re <= jet_pkg::sat32(re_sum);
            z_reg.im <= jet_pkg::sat32(im_sum);
            kc_reg   <= esc ? CW'(STEP) : km_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_z     = z_reg;
    assign out_count = kc_reg;

endmodule

`default_nettype wire

/* src/jet_color.sv */
`default_nettype none

// Last escape test, color lookup and the output register.
module jet_color #(
    parameter int MAX_ITERS = 64,
    parameter int CW        = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire jet_pkg::cfg_t              cfg,
    input  wire logic                       in_valid,
    input  wire jet_pkg::z_t                in_z,
    input  wire logic [CW-1:0]              in_count,
    output logic                            out_valid,
    output logic [23:0]                     out_rgb,
    output logic                            out_escaped,
    output logic [jet_pkg::CNT_W-1:0]       out_count
);

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

    // Color of escape step k, {blue, green, red}; step 0 is black
    function automatic logic [23:0] color_entry(int k);
        longint theta, x, x2, st, ssum, ct, csum, s, c, r, g, b;
        theta = (PI_Q30 * longint'(k)) / MAX_ITERS;
        x     = theta - HALF_PI_Q30;
        x2    = (x * x) >>> 30;
        st    = x;
        ssum  = x;
        ct    = Q30_ONE;
        csum  = Q30_ONE;
        for (int n = 0; n < 7; n++) begin
            st   = -(((st * x2) >>> 30) / SIN_DIV[n]);
            ssum = ssum + st;
            ct   = -(((ct * x2) >>> 30) / COS_DIV[n]);
            csum = csum + ct;
        end
        s = csum;
        c = -ssum;
        if (s < 0)        s = 0;
        if (s > Q30_ONE)  s = Q30_ONE;
        if (c < -Q30_ONE) c = -Q30_ONE;
        if (c > Q30_ONE)  c = Q30_ONE;
        r = ((Q30_ONE + c) * 255) >>> 31;
        g = ((Q30_ONE - c) * 255) >>> 31;
        b = (s * 255) >>> 30;
        return (k == 0) ? 24'h0 : {b[7:0], g[7:0], r[7:0]};
    endfunction

    logic [23:0]        rom [MAX_ITERS+1];

    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic [35:0]        mag;
    logic [CW-1:0]      k_fin;

    logic               vm_reg;
    logic               vo_reg;
    logic [62:0]        rr_reg;
    logic [62:0]        ii_reg;
    logic [CW-1:0]      km_reg;
    logic [23:0]        rgb_reg;
    logic [CW-1:0]      cnt_reg;

    // Constant color table
    for (genvar gi = 0; gi <= MAX_ITERS; gi++) begin : g_rom
        localparam logic [23:0] ENTRY = color_entry(gi);
        assign rom[gi] = ENTRY;
    end

    always_comb begin
        p_rr  = $signed(in_z.re) * $signed(in_z.re);
        p_ii  = $signed(in_z.im) * $signed(in_z.im);
        mag   = {1'b0, rr_reg[62:28]} + {1'b0, ii_reg[62:28]};
        k_fin = ((km_reg == '0) && (mag > 36'(cfg.escape_threshold)))
              ? CW'(MAX_ITERS) : km_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (advance) begin
            vm_reg <= in_valid;
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            rr_reg  <= p_rr[62:0];
            ii_reg  <= p_ii[62:0];
            km_reg  <= in_count;
            rgb_reg <= rom[k_fin];
            cnt_reg <= k_fin;
        end
    end

    assign out_valid   = vo_reg;
    assign out_rgb     = rgb_reg;
    assign out_escaped = (cnt_reg != '0);
    assign out_count   = jet_pkg::CNT_W'(cnt_reg);

endmodule

`default_nettype wire

/* src/julia_escape_time_pixel.sv */
// Julia-set escape-time pixel renderer.
// Input stream s_axis: one transaction per pixel, tdata = {row, column}.
// Output stream m_axis: one transaction per pixel, in input order;
//   tdata = {pad, iteration_count, blue, green, red}, tuser = escaped.
//   Pixels that never escape come out black with iteration_count 0.
// APB port: eight word registers (c, view center, inverse zoom, image
//   size, escape threshold); write only while no pixel is in flight.
// Throughput: one pixel per cycle. Path from acceptance to tvalid: the
//   11-stage coordinate path (entry register, 8 divider stages of 4
//   quotient bits each, zoom multiply, offset and saturate), two stages
//   per orbit step (three 32x32 multipliers, then add/saturate and escape
//   test) and two color stages.
// Stall: the whole pipeline halts while a result waits with tready low;
//   s_axis_tready drops in the same cycle, nothing is lost or repeated.
// Reset: rst_n clears all valid bits and loads register defaults; no
//   clearing pass, pixels are accepted as soon as rst_n is released.
`default_nettype none

module julia_escape_time_pixel #(
    parameter int MAX_ITERS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // column [11:0], row [23:12]
    input  wire logic [23:0]                 s_axis_tdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // red [7:0], green [15:8], blue [23:16], iteration_count [34:24], zero pad
    output logic [39:0]                      m_axis_tdata,
    // escaped [0]
    output logic                             m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jet_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [jet_pkg::DATA_W-1:0]  pwdata,
    output logic      [jet_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int CW = $clog2(MAX_ITERS + 1);

    jet_pkg::cfg_t               cfg;
    logic                        advance;
    logic [MAX_ITERS:0]          v_chain;
    jet_pkg::z_t                 z_chain [MAX_ITERS+1];
    logic [CW-1:0]               k_chain [MAX_ITERS+1];
    logic [23:0]                 rgb;
    logic [jet_pkg::CNT_W-1:0]   count;

    // Global pipeline enable
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    jet_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jet_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_col    (s_axis_tdata[11:0]),
        .in_row    (s_axis_tdata[23:12]),
        .out_valid (v_chain[0]),
        .out_z     (z_chain[0])
    );

    assign k_chain[0] = '0;

    // Orbit steps
    for (genvar i = 0; i < MAX_ITERS; i++) begin : g_iter
        jet_iter #(
            .STEP (i),
            .CW   (CW)
        ) u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cfg       (cfg),
            .in_valid  (v_chain[i]),
            .in_z      (z_chain[i]),
            .in_count  (k_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_z     (z_chain[i+1]),
            .out_count (k_chain[i+1])
        );
    end

    jet_color #(
        .MAX_ITERS (MAX_ITERS),
        .CW        (CW)
    ) u_color (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .cfg         (cfg),
        .in_valid    (v_chain[MAX_ITERS]),
        .in_z        (z_chain[MAX_ITERS]),
        .in_count    (k_chain[MAX_ITERS]),
        .out_valid   (m_axis_tvalid),
        .out_rgb     (rgb),
        .out_escaped (m_axis_tuser),
        .out_count   (count)
    );

    assign m_axis_tdata = {5'b0, count, rgb};

    // A pixel that never escaped is all zero
    a_black : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("non-escaped pixel carries color or count");

    // An escaped pixel reports a nonzero step
    a_step_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[34:24] != '0))
        else $error("escaped pixel with zero iteration count");

    // Escape step never exceeds the iteration limit
    a_step_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34:24] <= jet_pkg::CNT_W'(MAX_ITERS)))
        else $error("iteration count beyond limit");

endmodule

`default_nettype wire
